[design/gcg_pkg.sv]
package gcg_pkg;

	localparam int CoordBits = 16;
	localparam int FracBits  = 16;
	localparam int DiffBits  = CoordBits + 1;
	localparam int ProdBits  = 2 * DiffBits;
	localparam int SumBits   = ProdBits + 1;
	localparam int RootBits  = SumBits / 2 + 1;
	localparam int TBits     = FracBits + 1;
	localparam int NumRegs   = 8;

	typedef enum logic [1:0] {
		MODE_PLAIN  = 2'd0,
		MODE_FADE   = 2'd1,
		MODE_LINEAR = 2'd2,
		MODE_RADIAL = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		REG_MODE   = 3'd0,
		REG_COLOR_A = 3'd1,
		REG_COLOR_B = 3'd2,
		REG_COLOR_C = 3'd3,
		REG_COLOR_D = 3'd4,
		REG_ANCHOR = 3'd5,
		REG_AXIS_END = 3'd6,
		REG_RADIUS = 3'd7
	} reg_idx_t;

	typedef struct packed {
		mode_t                mode;
		logic [31:0]          color;
		logic signed [DiffBits-1:0] dx;
		logic signed [DiffBits-1:0] dy;
	} front_item_t;

	typedef struct packed {
		logic [31:0] color;
		logic        degenerate;
	} result_t;

	function automatic logic signed [DiffBits-1:0] coord_ext(input logic [15:0] v);
		logic signed [CoordBits-1:0] c;
		c = v[CoordBits-1:0];
		return DiffBits'(c);
	endfunction

endpackage

[design/gcg_front.sv]
module gcg_front
	import gcg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] px,
	input  logic [15:0] py,
	input  logic [2:0]  corner,
	input  mode_t       mode,
	input  logic [31:0] color_a,
	input  logic [31:0] color_b,
	input  logic [31:0] color_c,
	input  logic [31:0] color_d,
	input  logic [31:0] anchor,
	output logic        item_valid,
	input  logic        item_ready,
	output front_item_t item
);

	logic        valid_q;
	front_item_t item_q;
	front_item_t next_item;

	assign in_ready   = !valid_q || item_ready;
	assign item_valid = valid_q;
	assign item       = item_q;

	always_comb begin
		next_item.mode  = mode;
		next_item.color = color_a;
		if (mode == MODE_FADE) begin
			case (corner)
				3'd1: next_item.color = color_b;
				3'd2: next_item.color = color_c;
				3'd3: next_item.color = color_d;
				default: next_item.color = color_a;
			endcase
		end
		next_item.dx = coord_ext(px) - coord_ext(anchor[15:0]);
		next_item.dy = coord_ext(py) - coord_ext(anchor[31:16]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_q <= next_item;
		end
	end

endmodule

[design/gcg_fifo.sv]
module gcg_fifo
	import gcg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_valid,
	output logic        wr_ready,
	input  front_item_t wr_data,
	output logic        rd_valid,
	input  logic        rd_ready,
	output front_item_t rd_data
);

	front_item_t mem_q [2];
	logic        wp_q;
	logic        rp_q;
	logic [1:0]  cnt_q;
	logic        wr;
	logic        rd;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_data  = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= !wp_q;
			if (rd) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

endmodule

[design/gcg_back.sv]
module gcg_back
	import gcg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  front_item_t item,
	input  logic [31:0] color_a,
	input  logic [31:0] color_b,
	input  logic [31:0] anchor,
	input  logic [31:0] axis_end,
	input  logic [31:0] radius,
	output logic        res_valid,
	input  logic        res_ready,
	output result_t     res
);

	localparam int Stages   = 3 + RootBits + FracBits + 2;
	localparam int DenBits  = SumBits;
	localparam int RemBits  = SumBits + 2;

	typedef struct packed {
		mode_t               mode;
		logic [31:0]         color;
		logic signed [SumBits:0] num;
		logic [DenBits-1:0]  den;
		logic [SumBits-1:0]  rad;
		logic [RootBits-1:0] root;
		logic [RemBits-1:0]  rem;
		logic [TBits-1:0]    t;
		logic                degen;
		logic                step;
	} work_t;

	logic [Stages-1:0] v_s;
	work_t             w_s [Stages];
	logic              adv;
	logic signed [DiffBits-1:0] ex;
	logic signed [DiffBits-1:0] ey;

	assign adv        = !v_s[Stages-1] || res_ready;
	assign item_ready = adv;
	assign res_valid  = v_s[Stages-1];
	assign res.color      = w_s[Stages-1].color;
	assign res.degenerate = w_s[Stages-1].degen;
	assign ex = coord_ext(axis_end[15:0]) - coord_ext(anchor[15:0]);
	assign ey = coord_ext(axis_end[31:16]) - coord_ext(anchor[31:16]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (adv) begin
			v_s <= {v_s[Stages-2:0], item_valid};
		end
	end

	// stage 0: products; 1: sums; then root bits, divide setup, divide bits, a spare stage, blend
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int s = Stages - 1; s >= 0; s--) begin
				work_t w;
				w = (s == 0) ? work_t'(0) : w_s[s-1];
				if (s == 0) begin
					w.mode  = item.mode;
					w.color = item.color;
					if (item.mode == MODE_LINEAR) begin
						w.num = (SumBits+1)'(item.dx * ex);
						w.rad = SumBits'(item.dy * ey);
						w.den = DenBits'(ex * ex);
						w.rem = RemBits'(ey * ey);
					end else begin
						w.rad = SumBits'(item.dx * item.dx);
						w.rem = RemBits'(item.dy * item.dy);
					end
				end else if (s == 1) begin
					if (w.mode == MODE_LINEAR) begin
						w.num = w.num + (SumBits+1)'($signed(w.rad));
						w.den = w.den + DenBits'(w.rem);
					end else begin
						w.rad = w.rad + SumBits'(w.rem);
					end
					w.root = '0;
					w.rem  = '0;
				end else if (s >= 2 && s < 2 + RootBits) begin
					logic [RemBits-1:0] trial;
					logic [RemBits-1:0] r2;
					int k;
					k  = RootBits - 1 - (s - 2);
					r2 = (w.rem << 2) | RemBits'((w.rad >> (2*k)) & 2'b11);
					trial = RemBits'({w.root, 2'b01});
					if (r2 >= trial) begin
						w.rem  = r2 - trial;
						w.root = {w.root[RootBits-2:0], 1'b1};
					end else begin
						w.rem  = r2;
						w.root = {w.root[RootBits-2:0], 1'b0};
					end
				end else if (s == 2 + RootBits) begin
					logic signed [SumBits:0] dnum;
					logic signed [SumBits:0] dden;
					if (w.mode == MODE_RADIAL) begin
						dnum = (SumBits+1)'(w.root) - (SumBits+1)'(radius[15:0]);
						dden = (SumBits+1)'(radius[31:16]) - (SumBits+1)'(radius[15:0]);
						w.step = dnum > 0;
						if (dden < 0) begin
							dden = -dden;
							dnum = -dnum;
						end
						w.num = dnum;
						w.den = DenBits'(dden);
					end
					w.degen = (w.mode == MODE_LINEAR || w.mode == MODE_RADIAL) && w.den == '0;
					w.t   = '0;
					if (w.degen) begin
						w.t = (w.mode == MODE_RADIAL && w.step) ? TBits'(1) << FracBits : '0;
						w.rem = '0;
					end else if (w.num <= 0) begin
						w.rem = '0;
					end else if (RemBits'(w.num) >= RemBits'(w.den)) begin
						w.t = TBits'(1) << FracBits;
						w.rem = '0;
					end else begin
						w.rem = RemBits'(w.num);
						w.step = 1'b1;
					end
					if (!(w.num > 0 && !w.degen && RemBits'(w.num) < RemBits'(w.den)))
						w.step = 1'b0;
				end else if (s < 3 + RootBits + FracBits) begin
					logic [RemBits-1:0] r2;
					if (w.step) begin
						r2 = w.rem << 1;
						if (r2 >= RemBits'(w.den)) begin
							w.rem = r2 - RemBits'(w.den);
							w.t   = {w.t[TBits-2:0], 1'b1};
						end else begin
							w.rem = r2;
							w.t   = {w.t[TBits-2:0], 1'b0};
						end
					end
				end else if (s == 3 + RootBits + FracBits) begin
					w.rad = '0;
				end else begin
					if (w.mode == MODE_LINEAR || w.mode == MODE_RADIAL) begin
						for (int c = 0; c < 4; c++) begin
							logic [TBits+8-1:0] acc;
							acc = (TBits+8)'(w.t) * (TBits+8)'(color_b[8*c +: 8])
								+ (TBits+8)'(TBits'(1 << FracBits) - w.t)
								* (TBits+8)'(color_a[8*c +: 8]);
							w.color[8*c +: 8] = acc[FracBits +: 8];
						end
					end else begin
						w.degen = 1'b0;
					end
				end
				w_s[s] <= w;
			end
		end
	end

endmodule

[design/gradient_color_generator.sv]
// Gradient color generator: one pixel (x, y, corner) in, one RGBA color out, one item
// per clock while the output is not stalled. The back end holds a bit-serial square root
// and a bit-serial divide pipeline. The user writes registers through the cfg channel
// only while the block is idle; the block itself does not enforce this.
module gradient_color_generator
	import gcg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // pixel_x, pixel_y, corner_index, zero pad
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // red, green, blue, alpha, degenerate, zero pad
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	mode_t       mode_q;
	logic [31:0] regs_q [1:NumRegs-1];
	front_item_t f_item;
	front_item_t q_item;
	logic        f_valid, f_ready, q_valid, q_ready, r_valid;
	result_t     r_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_PLAIN;
			for (int i = 1; i < NumRegs; i++)
				regs_q[i] <= (i == int'(REG_COLOR_A)) ? 32'hFFFF_FFFF : 32'h0;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_MODE: mode_q <= mode_t'(cfg_data[1:0]);
				default: regs_q[cfg_index] <= cfg_data;
			endcase
		end
	end

	gcg_front u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.px(s_axis_tdata[15:0]), .py(s_axis_tdata[31:16]), .corner(s_axis_tdata[34:32]),
		.mode(mode_q), .color_a(regs_q[REG_COLOR_A]), .color_b(regs_q[REG_COLOR_B]),
		.color_c(regs_q[REG_COLOR_C]), .color_d(regs_q[REG_COLOR_D]),
		.anchor(regs_q[REG_ANCHOR]),
		.item_valid(f_valid), .item_ready(f_ready), .item(f_item)
	);

	gcg_fifo u_fifo (
		.clk, .arst_n,
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_item),
		.rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_item)
	);

	gcg_back u_back (
		.clk, .arst_n,
		.item_valid(q_valid), .item_ready(q_ready), .item(q_item),
		.color_a(regs_q[REG_COLOR_A]), .color_b(regs_q[REG_COLOR_B]),
		.anchor(regs_q[REG_ANCHOR]), .axis_end(regs_q[REG_AXIS_END]),
		.radius(regs_q[REG_RADIUS]),
		.res_valid(r_valid), .res_ready(m_axis_tready), .res(r_item)
	);

	assign m_axis_tvalid = r_valid;
	assign m_axis_tdata  = {7'd0, r_item.degenerate, r_item.color};

endmodule

[design/gcg_checker.sv]
module gcg_props (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata,
	input logic        cfg_valid,
	input logic        cfg_ready
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[39:33] == 7'd0)
		else $error("pad bits set");

	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("cfg write refused");

endmodule

bind gradient_color_generator gcg_props u_gcg_props (
	.clk, .arst_n, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_valid, .cfg_ready
);

[tb/gcg_checker.sv]
module gcg_checker
	import gcg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [39:0] m_axis_tdata,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int          fail_count,
	output int          pending_colors,
	output int          colors_seen,
	output int          degenerate_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	mode_t       mode_q;
	logic [31:0] col_a, col_b, col_c, col_d, anchor_q, axis_q, radius_q;
	logic [32:0] color_queue[$];

	function automatic longint sext16(input logic [15:0] v);
		return longint'($signed(v));
	endfunction

	function automatic longint int_sqrt(input longint v);
		longint r, b;
		r = 0;
		b = 64'sd1 << 62;
		while (b > v)
			b = b >>> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >>> 1) + b;
			end else begin
				r = r >>> 1;
			end
			b = b >>> 2;
		end
		return r;
	endfunction

	function automatic longint clamp_frac(input longint num, input longint den);
		if (num <= 0)
			return 0;
		if (num >= den)
			return longint'(1) << FracBits;
		return (num << FracBits) / den;
	endfunction

	function automatic logic [31:0] mix_colors(input longint t);
		logic [31:0] res;
		longint      a, b;
		for (int sh = 0; sh < 32; sh += 8) begin
			a = (col_a >> sh) & 8'hFF;
			b = (col_b >> sh) & 8'hFF;
			res[sh+:8] = 8'((t * b + ((longint'(1) << FracBits) - t) * a) >>> FracBits);
		end
		return res;
	endfunction

	function automatic logic [32:0] shade_pixel(input logic [39:0] d);
		longint      px, py, sx, sy, ex, ey, num, den, rad_len, inner, outer;
		logic [31:0] color;
		logic        degen;
		px = sext16(d[15:0]);
		py = sext16(d[31:16]);
		sx = sext16(anchor_q[15:0]);
		sy = sext16(anchor_q[31:16]);
		color = col_a;
		degen = 1'b0;
		case (mode_q)
			MODE_FADE: begin
				case (d[34:32])
					3'd1: color = col_b;
					3'd2: color = col_c;
					3'd3: color = col_d;
					default: color = col_a;
				endcase
			end
			MODE_LINEAR: begin
				ex = sext16(axis_q[15:0]) - sx;
				ey = sext16(axis_q[31:16]) - sy;
				num = (px - sx) * ex + (py - sy) * ey;
				den = ex * ex + ey * ey;
				if (den == 0) begin
					degen = 1'b1;
					color = mix_colors(0);
				end else begin
					color = mix_colors(clamp_frac(num, den));
				end
			end
			MODE_RADIAL: begin
				rad_len = int_sqrt((px - sx) * (px - sx) + (py - sy) * (py - sy));
				inner = longint'(radius_q[15:0]);
				outer = longint'(radius_q[31:16]);
				num = rad_len - inner;
				den = outer - inner;
				if (den == 0) begin
					degen = 1'b1;
					color = mix_colors(rad_len > inner ? (longint'(1) << FracBits) : 0);
				end else begin
					if (den < 0) begin
						den = -den;
						num = -num;
					end
					color = mix_colors(clamp_frac(num, den));
				end
			end
			default: color = col_a;
		endcase
		return {degen, color};
	endfunction

	assign pending_colors = color_queue.size();

	always @(posedge clk or negedge arst_n) begin
		logic [32:0] want;
		int          errs;
		errs = 0;
		if (!arst_n) begin
			mode_q <= MODE_PLAIN;
			col_a <= '1;
			col_b <= '0;
			col_c <= '0;
			col_d <= '0;
			anchor_q <= '0;
			axis_q <= '0;
			radius_q <= '0;
			fail_count <= 0;
			colors_seen <= 0;
			degenerate_seen <= 0;
			color_queue.delete();
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				color_queue.push_back(shade_pixel(s_axis_tdata));
			if (m_axis_tvalid && m_axis_tready) begin
				colors_seen <= colors_seen + 1;
				if (m_axis_tdata[32])
					degenerate_seen <= degenerate_seen + 1;
				if (color_queue.size() == 0) begin
					$error("unexpected color transfer %h", m_axis_tdata);
					errs++;
				end else begin
					want = color_queue.pop_front();
					if (m_axis_tdata[7:0] !== want[7:0]) begin
						$error("red: expected %0d, got %0d", want[7:0], m_axis_tdata[7:0]);
						errs++;
					end
					if (m_axis_tdata[15:8] !== want[15:8]) begin
						$error("green: expected %0d, got %0d", want[15:8], m_axis_tdata[15:8]);
						errs++;
					end
					if (m_axis_tdata[23:16] !== want[23:16]) begin
						$error("blue: expected %0d, got %0d", want[23:16],
							m_axis_tdata[23:16]);
						errs++;
					end
					if (m_axis_tdata[31:24] !== want[31:24]) begin
						$error("alpha: expected %0d, got %0d", want[31:24],
							m_axis_tdata[31:24]);
						errs++;
					end
					if (m_axis_tdata[32] !== want[32]) begin
						$error("degenerate: expected %0d, got %0d", want[32], m_axis_tdata[32]);
						errs++;
					end
				end
			end
			if (errs != 0)
				fail_count <= fail_count + errs;
			if (cfg_valid && cfg_ready) begin
				case (reg_idx_t'(cfg_index))
					REG_MODE:     mode_q <= mode_t'(cfg_data[1:0]);
					REG_COLOR_A:  col_a <= cfg_data;
					REG_COLOR_B:  col_b <= cfg_data;
					REG_COLOR_C:  col_c <= cfg_data;
					REG_COLOR_D:  col_d <= cfg_data;
					REG_ANCHOR:   anchor_q <= cfg_data;
					REG_AXIS_END: axis_q <= cfg_data;
					REG_RADIUS:   radius_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

endmodule

[tb/tb_gradient_color_generator.sv]
module tb_gradient_color_generator
	import gcg_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int Latency    = 3 + RootBits + FracBits + 3;
	localparam int StallLimit = 5000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;
	int          fail_count, pending_colors, colors_seen, degenerate_seen;
	int          idle_cycles = 0;
	int          hold_off = 0;
	int          sink_gap = 0;
	bit          calm = 1'b0;
	bit          sink_free = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	gradient_color_generator dut (.*);

	gcg_checker checker_i (.*);

	// receiver: random stall bursts, one long hold-off on request, none at the end
	always @(posedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			m_axis_tready <= 1'b0;
		end else if (calm || sink_free) begin
			m_axis_tready <= 1'b1;
		end else if (sink_gap > 0) begin
			sink_gap <= sink_gap - 1;
			m_axis_tready <= 1'b0;
		end else if ($urandom_range(0, 5) == 0) begin
			sink_gap <= $urandom_range(0, 9);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
			(cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > StallLimit) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_pixel(input logic [15:0] x, input logic [15:0] y,
		input logic [2:0] corner);
		int gap;
		if (!calm && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 10);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {5'b0, corner, y, x};
		do
			@(posedge clk);
		while (!s_axis_tready);
	endtask

	task automatic drain;
		s_axis_tvalid <= 1'b0;
		sink_free = 1'b1;
		while (pending_colors != 0)
			@(posedge clk);
		repeat (Latency + 5) @(posedge clk);
		sink_free = 1'b0;
	endtask

	function automatic logic [15:0] rand_coord();
		case ($urandom_range(0, 3))
			0: return 16'($urandom_range(0, 64) - 32);
			1: return 16'($urandom_range(0, 1024) - 512);
			2: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_setup(input mode_t m);
		write_reg(REG_MODE, {30'b0, m});
		write_reg(REG_COLOR_A, $urandom);
		write_reg(REG_COLOR_B, $urandom);
		write_reg(REG_COLOR_C, $urandom);
		write_reg(REG_COLOR_D, $urandom);
		write_reg(REG_ANCHOR, {rand_coord(), rand_coord()});
		write_reg(REG_AXIS_END, ($urandom_range(0, 7) == 0) ? 32'h0 :
			{rand_coord(), rand_coord()});
		case ($urandom_range(0, 4))
			0: write_reg(REG_RADIUS, {2{16'($urandom_range(0, 300))}});
			1: write_reg(REG_RADIUS, $urandom);
			default: write_reg(REG_RADIUS, {16'($urandom_range(0, 1000)),
				16'($urandom_range(0, 1000))});
		endcase
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset defaults, then every mode and the degenerate cases
		send_pixel(16'h0000, 16'h0000, 3'd0);
		drain();
		write_reg(REG_COLOR_A, 32'h00000000);
		write_reg(REG_COLOR_B, 32'hFFFFFFFF);
		write_reg(REG_COLOR_C, 32'h11223344);
		write_reg(REG_COLOR_D, 32'hA5A5A5A5);
		write_reg(REG_MODE, {30'b0, MODE_FADE});
		for (int c = 0; c < 8; c++)
			send_pixel(16'h7FFF, 16'h8000, 3'(c));
		drain();
		write_reg(REG_MODE, {30'b0, MODE_LINEAR});
		send_pixel(16'h0005, 16'h0005, 3'd7);
		drain();
		write_reg(REG_ANCHOR, {16'h8000, 16'h8000});
		write_reg(REG_AXIS_END, {16'h7FFF, 16'h7FFF});
		send_pixel(16'h8000, 16'h8000, 3'd0);
		send_pixel(16'h7FFF, 16'h7FFF, 3'd0);
		send_pixel(16'h0000, 16'h0000, 3'd0);
		send_pixel(16'hFFFF, 16'h0001, 3'd0);
		drain();
		write_reg(REG_MODE, {30'b0, MODE_RADIAL});
		write_reg(REG_ANCHOR, 32'h0);
		write_reg(REG_RADIUS, {16'd10, 16'd10});
		send_pixel(16'd10, 16'd0, 3'd0);
		send_pixel(16'd11, 16'd0, 3'd0);
		drain();
		write_reg(REG_RADIUS, {16'd0, 16'd100});
		send_pixel(16'd30, 16'd40, 3'd0);
		send_pixel(16'h8000, 16'h8000, 3'd0);
		drain();
		write_reg(REG_RADIUS, {16'hFFFF, 16'h0000});
		send_pixel(16'd3, 16'd4, 3'd0);
		send_pixel(16'h7FFF, 16'h8000, 3'd0);
		drain();

		// long receiver hold-off while the source keeps pushing
		hold_off = 300;
		for (int i = 0; i < 100; i++)
			send_pixel(rand_coord(), rand_coord(), 3'($urandom));
		drain();

		for (int p = 0; p < 14; p++) begin
			random_setup(mode_t'(p % 4));
			if (p == 12)
				calm = 1'b1;
			for (int i = 0; i < 50; i++)
				send_pixel(rand_coord(), rand_coord(), 3'($urandom));
			drain();
		end

		$display("Covered all four shading modes over %0d colors, %0d degenerate.",
			colors_seen, degenerate_seen);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

[gradient_color_generator.f]
design/gcg_pkg.sv
design/gcg_front.sv
design/gcg_fifo.sv
design/gcg_back.sv
design/gradient_color_generator.sv
design/gcg_checker.sv
tb/gcg_checker.sv
tb/tb_gradient_color_generator.sv
